// ===== hw/rtl/vbd_pkg.sv =====
// Shared types and constants for the volume box downsampler.
package vbd_pkg;

   localparam int unsigned SRC_MAX   = 64;
   localparam int unsigned RATIO_MAX = 8;
   localparam logic [27:0] Q_ONE     = 28'h100_0000;
   localparam logic [27:0] Q_MAX     = 28'(RATIO_MAX * 32'h100_0000);
   localparam int unsigned DIV_W     = 25;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_REQ  = 1'b1;

   localparam logic [2:0] REG_SRC_W = 3'd0;
   localparam logic [2:0] REG_SRC_H = 3'd1;
   localparam logic [2:0] REG_SRC_D = 3'd2;
   localparam logic [2:0] REG_DST_W = 3'd3;
   localparam logic [2:0] REG_DST_H = 3'd4;
   localparam logic [2:0] REG_RATIO = 3'd5;

   typedef struct packed {
      logic              op;
      logic signed [15:0] sample_hu;
      logic [5:0]        src_col;
      logic [5:0]        src_row;
      logic [5:0]        src_slice;
      logic [5:0]        dst_x;
      logic [5:0]        dst_y;
      logic [5:0]        dst_z;
   } in_type;

   typedef struct packed {
      logic [15:0] voxel_value;
      logic [17:0] dst_index;
      logic        box_error;
   } out_type;

   // Effective configuration after clamping of source sizes and ratio
   typedef struct packed {
      logic [6:0]  src_w;
      logic [6:0]  src_h;
      logic [6:0]  src_d;
      logic [6:0]  dst_w;
      logic [6:0]  dst_h;
      logic [27:0] ratio;
   } cfg_type;

   // One classified job between front and back
   typedef struct packed {
      logic        is_req;
      logic        box_err;
      logic [15:0] sample;
      logic [17:0] addr;
      logic [5:0]  x0;
      logic [5:0]  y0;
      logic [5:0]  z0;
      logic [6:0]  x1;
      logic [6:0]  y1;
      logic [6:0]  z1;
      logic [17:0] idx;
      logic [9:0]  cnt;
   } job_type;

   typedef enum logic [1:0] {FS_IDLE, FS_CALC, FS_PUSH} front_state_type;
   typedef enum logic [2:0] {BS_IDLE, BS_WALK, BS_DRAIN, BS_DSET, BS_DIV, BS_OUT}
      back_state_type;

endpackage

// ===== hw/rtl/volume_box_downsampler.sv =====
// Top level of the volume box downsampler: register port, front, queue, back.
//
// Usage: a beat on req_data is taken at a clock edge with start high and
// busy low. A load beat (op 0) writes one signed sample into the 64x64x64
// source store; a request beat (op 1) yields exactly one result beat on
// rsp_data, marked by a one-cycle rsp_valid, which the receiver must take.
// Loads give no result.
// The front moves a load straight to its push state; a request first forms its
// bounds from one shared 7x28 multiplier, then its index and count products.
// The back writes a load into the store as it pops it; a request walks its box
// at one store read per cycle (up to 512 for ratio 8), then runs a 25-step
// restoring divider. Out-of-source boxes skip the walk and are answered with a
// zero value and box_error set. A two-entry queue lets the front take beats
// while the back works; busy is high while the front holds a beat.
// Reset clears control state and restores the register defaults; the store
// content is undefined until loaded. The user must write registers over the
// APB port only while the block is idle; the block does not enforce this.
module volume_box_downsampler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vbd_pkg::in_type  req_data,
   output logic             rsp_valid,
   output vbd_pkg::out_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [6:0] SIZE_MAX = 7'(vbd_pkg::SRC_MAX);

   logic [6:0]  src_w_ff, src_h_ff, src_d_ff, dst_w_ff, dst_h_ff;
   logic [27:0] ratio_ff;
   vbd_pkg::cfg_type cfg;
   vbd_pkg::job_type push_job, head;
   logic q_push, q_pop, q_full, q_empty;

   assign pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SIZE_MAX;
         src_h_ff <= SIZE_MAX;
         src_d_ff <= SIZE_MAX;
         dst_w_ff <= 7'd64;
         dst_h_ff <= 7'd64;
         ratio_ff <= vbd_pkg::Q_ONE;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            vbd_pkg::REG_SRC_W: src_w_ff <= pwdata[6:0];
            vbd_pkg::REG_SRC_H: src_h_ff <= pwdata[6:0];
            vbd_pkg::REG_SRC_D: src_d_ff <= pwdata[6:0];
            vbd_pkg::REG_DST_W: dst_w_ff <= pwdata[6:0];
            vbd_pkg::REG_DST_H: dst_h_ff <= pwdata[6:0];
            vbd_pkg::REG_RATIO: ratio_ff <= pwdata[27:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[4:2])
         vbd_pkg::REG_SRC_W: prdata = {25'd0, src_w_ff};
         vbd_pkg::REG_SRC_H: prdata = {25'd0, src_h_ff};
         vbd_pkg::REG_SRC_D: prdata = {25'd0, src_d_ff};
         vbd_pkg::REG_DST_W: prdata = {25'd0, dst_w_ff};
         vbd_pkg::REG_DST_H: prdata = {25'd0, dst_h_ff};
         vbd_pkg::REG_RATIO: prdata = {4'd0, ratio_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Clamp source sizes to 1..64 and ratio to 1.0..8.0; destination sizes pass
   always_comb begin
      cfg.src_w = (src_w_ff == 7'd0) ? 7'd1 : (src_w_ff > SIZE_MAX) ? SIZE_MAX : src_w_ff;
      cfg.src_h = (src_h_ff == 7'd0) ? 7'd1 : (src_h_ff > SIZE_MAX) ? SIZE_MAX : src_h_ff;
      cfg.src_d = (src_d_ff == 7'd0) ? 7'd1 : (src_d_ff > SIZE_MAX) ? SIZE_MAX : src_d_ff;
      cfg.dst_w = dst_w_ff;
      cfg.dst_h = dst_h_ff;
      cfg.ratio = (ratio_ff < vbd_pkg::Q_ONE) ? vbd_pkg::Q_ONE
                : (ratio_ff > vbd_pkg::Q_MAX) ? vbd_pkg::Q_MAX : ratio_ff;
   end

   vbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   vbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   vbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/vbd_front.sv =====
// Front end: accepts beats, computes box bounds, index and count for requests, pushes jobs.
module vbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vbd_pkg::in_type   req_data,
   input  vbd_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              q_push,
   output vbd_pkg::job_type  q_job
);

   vbd_pkg::front_state_type state_ff, state_in;
   vbd_pkg::in_type          item_ff;
   logic [3:0]  step_ff, step_in;
   logic [9:0]  x0_ff, x1_ff, y0_ff, y1_ff, z0_ff, z1_ff;
   logic [13:0] t_ff;
   logic [17:0] idx_ff;
   logic [6:0]  dxy_ff;
   logic [9:0]  cnt_ff;
   logic [6:0]  coord;
   logic [34:0] prod;
   logic [9:0]  bnd;
   logic [3:0]  dx, dy, dz;
   logic [20:0] idx_full;
   logic        accept, err;

   assign busy   = (state_ff != vbd_pkg::FS_IDLE);
   assign accept = start && !busy;

   // Shared bound multiplier: coordinate (or coordinate plus one) times ratio
   always_comb begin
      unique case (step_ff)
         4'd0:    coord = {1'b0, item_ff.dst_x};
         4'd1:    coord = {1'b0, item_ff.dst_x} + 7'd1;
         4'd2:    coord = {1'b0, item_ff.dst_y};
         4'd3:    coord = {1'b0, item_ff.dst_y} + 7'd1;
         4'd4:    coord = {1'b0, item_ff.dst_z};
         default: coord = {1'b0, item_ff.dst_z} + 7'd1;
      endcase
   end
   assign prod = {28'd0, coord} * {7'd0, cfg.ratio};
   assign bnd  = prod[33:24];

   assign dx = 4'(x1_ff - x0_ff);
   assign dy = 4'(y1_ff - y0_ff);
   assign dz = 4'(z1_ff - z0_ff);
   assign idx_full = {15'd0, item_ff.dst_x}
                   + ({14'd0, cfg.dst_w} * {7'd0, t_ff});
   assign err = (x1_ff > {3'd0, cfg.src_w}) || (y1_ff > {3'd0, cfg.src_h})
             || (z1_ff > {3'd0, cfg.src_d});

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         vbd_pkg::FS_IDLE: begin
            if (accept) begin
               step_in  = 4'd0;
               state_in = (req_data.op == vbd_pkg::OP_REQ) ? vbd_pkg::FS_CALC
                                                           : vbd_pkg::FS_PUSH;
            end
         end
         vbd_pkg::FS_CALC: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd9) state_in = vbd_pkg::FS_PUSH;
         end
         default: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = vbd_pkg::FS_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vbd_pkg::FS_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Datapath registers, one product per step
   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      if (state_ff == vbd_pkg::FS_CALC) begin
         unique case (step_ff)
            4'd0: x0_ff <= bnd;
            4'd1: x1_ff <= bnd;
            4'd2: y0_ff <= bnd;
            4'd3: y1_ff <= bnd;
            4'd4: z0_ff <= bnd;
            4'd5: z1_ff <= bnd;
            4'd6: t_ff  <= {8'd0, item_ff.dst_y}
                         + ({7'd0, cfg.dst_h} * {8'd0, item_ff.dst_z});
            4'd7: idx_ff <= idx_full[17:0];
            4'd8: dxy_ff <= 7'({4'd0, dx} * {4'd0, dy});
            default: cnt_ff <= 10'({3'd0, dxy_ff} * {6'd0, dz});
         endcase
      end
   end

   always_comb begin
      q_job.is_req  = item_ff.op;
      q_job.box_err = err;
      q_job.sample  = item_ff.sample_hu;
      q_job.addr    = {item_ff.src_slice, item_ff.src_row, item_ff.src_col};
      q_job.x0      = x0_ff[5:0];
      q_job.y0      = y0_ff[5:0];
      q_job.z0      = z0_ff[5:0];
      q_job.x1      = x1_ff[6:0];
      q_job.y1      = y1_ff[6:0];
      q_job.z1      = z1_ff[6:0];
      q_job.idx     = idx_ff;
      q_job.cnt     = cnt_ff;
   end

endmodule

// ===== hw/rtl/vbd_queue.sv =====
// Two-entry job queue between front and back.
module vbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vbd_pkg::job_type push_job,
   input  logic             pop,
   output vbd_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   vbd_pkg::job_type ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_job;
   end

endmodule

// ===== hw/rtl/vbd_back.sv =====
// Back end: sample store, box walk, accumulate, divide and result beat.
module vbd_back (
   input  logic             clock,
   input  logic             reset,
   input  vbd_pkg::cfg_type cfg,
   input  vbd_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_valid,
   output vbd_pkg::out_type rsp_data
);

   vbd_pkg::back_state_type state_ff, state_in;
   vbd_pkg::job_type        job_ff;
   logic [15:0] mem_ff [262144];
   logic [15:0] rd_data_ff;
   logic [17:0] rd_addr;
   logic        pend_ff;
   logic [5:0]  sx_ff, sy_ff, sz_ff;
   logic signed [25:0] sum_ff;
   logic        neg_ff;
   logic [vbd_pkg::DIV_W-1:0] quo_ff;
   logic [10:0] rem_ff, rem_sh;
   logic [4:0]  dstep_ff;
   logic        last, x_end, y_end;
   logic [5:0]  mc, mr;
   logic signed [26:0] avg, ofs;
   logic [11:0] sat;
   logic        out_valid_ff;
   vbd_pkg::out_type out_ff;

   assign x_end = ({1'b0, sx_ff} + 7'd1 == job_ff.x1);
   assign y_end = ({1'b0, sy_ff} + 7'd1 == job_ff.y1);
   assign last  = x_end && y_end && ({1'b0, sz_ff} + 7'd1 == job_ff.z1);
   assign mc = 6'(cfg.src_w - 7'd1 - {1'b0, sx_ff});
   assign mr = 6'(cfg.src_h - 7'd1 - {1'b0, sy_ff});
   assign rd_addr = {sz_ff, mr, mc};
   assign pop = (state_ff == vbd_pkg::BS_IDLE) && !empty;

   // Sample store
   always_ff @(posedge clock) begin
      if (pop && !head.is_req) mem_ff[head.addr] <= head.sample;
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vbd_pkg::BS_IDLE:
            if (pop && head.is_req && !head.box_err) state_in = vbd_pkg::BS_WALK;
         vbd_pkg::BS_WALK:  if (last) state_in = vbd_pkg::BS_DRAIN;
         vbd_pkg::BS_DRAIN: state_in = vbd_pkg::BS_DSET;
         vbd_pkg::BS_DSET:  state_in = vbd_pkg::BS_DIV;
         vbd_pkg::BS_DIV:
            if (dstep_ff == 5'(vbd_pkg::DIV_W - 1)) state_in = vbd_pkg::BS_OUT;
         default: state_in = vbd_pkg::BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vbd_pkg::BS_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= (state_ff == vbd_pkg::BS_WALK);
         out_valid_ff <= (pop && head.is_req && head.box_err)
                      || (state_ff == vbd_pkg::BS_OUT);
      end
   end

   // Restoring divide step
   assign rem_sh = {rem_ff[9:0], quo_ff[vbd_pkg::DIV_W-1]};

   // Final scaling and clamp
   assign avg = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign ofs = avg + 27'sd1024;
   always_comb begin
      if (ofs < 0)              sat = 12'd0;
      else if (ofs > 27'sd4095) sat = 12'd4095;
      else                      sat = ofs[11:0];
   end

   always_ff @(posedge clock) begin
      // Job launch and walk counters
      if (pop) begin
         job_ff <= head;
         sx_ff  <= head.x0;
         sy_ff  <= head.y0;
         sz_ff  <= head.z0;
         sum_ff <= '0;
         if (head.is_req && head.box_err) begin
            out_ff.voxel_value <= 16'd0;
            out_ff.dst_index   <= head.idx;
            out_ff.box_error   <= 1'b1;
         end
      end else if (state_ff == vbd_pkg::BS_WALK) begin
         if (x_end) begin
            sx_ff <= job_ff.x0;
            if (y_end) begin
               sy_ff <= job_ff.y0;
               sz_ff <= sz_ff + 6'd1;
            end else begin
               sy_ff <= sy_ff + 6'd1;
            end
         end else begin
            sx_ff <= sx_ff + 6'd1;
         end
      end
      // Accumulate each returned beat of read data
      if (pend_ff) sum_ff <= sum_ff + 26'($signed(rd_data_ff));
      // Divider
      if (state_ff == vbd_pkg::BS_DSET) begin
         neg_ff   <= sum_ff[25];
         quo_ff   <= sum_ff[25] ? vbd_pkg::DIV_W'(-sum_ff)
                                : vbd_pkg::DIV_W'(sum_ff);
         rem_ff   <= '0;
         dstep_ff <= 5'd0;
      end else if (state_ff == vbd_pkg::BS_DIV) begin
         dstep_ff <= dstep_ff + 5'd1;
         if (rem_sh >= {1'b0, job_ff.cnt}) begin
            rem_ff <= rem_sh - {1'b0, job_ff.cnt};
            quo_ff <= {quo_ff[vbd_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[vbd_pkg::DIV_W-2:0], 1'b0};
         end
      end else if (state_ff == vbd_pkg::BS_OUT) begin
         out_ff.voxel_value <= {sat, 4'd0};
         out_ff.dst_index   <= job_ff.idx;
         out_ff.box_error   <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
